// ===== rtl/byte_ring_pipe_with_refcount_unit_defines.svh =====
// Assertion macros shared by the pipe unit.
`ifndef BYTE_RING_PIPE_WITH_REFCOUNT_UNIT_DEFINES_SVH
`define BYTE_RING_PIPE_WITH_REFCOUNT_UNIT_DEFINES_SVH

// Assert that a condition implies a same-cycle consequence.
`define BRP_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define BRP_ASSERT_NXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/brp_pkg.sv =====
package brp_pkg;

    localparam int PIPE_DEPTH_DEF = 2048;
    localparam int MAX_READ_DEF   = 64;
    localparam int QDEPTH         = 2;

    localparam logic [2:0] FN_OPEN  = 3'd0;
    localparam logic [2:0] FN_DUP   = 3'd1;
    localparam logic [2:0] FN_CLOSE = 3'd2;
    localparam logic [2:0] FN_FINAL = 3'd3;
    localparam logic [2:0] FN_WRITE = 3'd4;
    localparam logic [2:0] FN_READ  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NCONN = 2'd1;
    localparam logic [1:0] ST_BLOCK = 2'd2;
    localparam logic [1:0] ST_NOSPC = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic        nonblocking;
        logic [11:0] length;
        logic [7:0]  data_byte;
        logic        burst_last;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [11:0] done_count;
        logic [15:0] ref_count;
        logic        is_open;
        logic        last;
    } t_out;

    // Back-end command kinds.
    typedef enum logic [1:0] {
        CMD_CTRL,
        CMD_WRITE,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [2:0]  func;
        logic [11:0] length;
        logic [7:0]  data_byte;
        logic        burst_last;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_RDLAT,
        BS_RDOUT
    } t_bstate;

endpackage

// ===== rtl/brp_front.sv =====
module brp_front #(
    parameter int MAX_READ = brp_pkg::MAX_READ_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  brp_pkg::t_in   i_req,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output brp_pkg::t_cmd  o_q_cmd
);

    localparam int QW = $clog2(brp_pkg::QDEPTH);

    brp_pkg::t_cmd        r_q [brp_pkg::QDEPTH];
    logic [QW-1:0]        r_wp, r_rp;
    logic [QW:0]          r_cnt;
    brp_pkg::t_cmd        n_cmd;
    logic                 push;
    logic                 known;

    // Classify the request and clamp read lengths.
    always_comb begin
        n_cmd            = '0;
        n_cmd.func       = i_req.func;
        n_cmd.data_byte  = i_req.data_byte;
        n_cmd.burst_last = i_req.burst_last;
        n_cmd.length     = i_req.length;
        known            = 1'b1;
        case (i_req.func)
            brp_pkg::FN_WRITE: n_cmd.kind = brp_pkg::CMD_WRITE;
            brp_pkg::FN_READ: begin
                n_cmd.kind = brp_pkg::CMD_READ;
                if (i_req.length > 12'(MAX_READ)) n_cmd.length = 12'(MAX_READ);
            end
            brp_pkg::FN_OPEN, brp_pkg::FN_DUP, brp_pkg::FN_CLOSE, brp_pkg::FN_FINAL:
                n_cmd.kind = brp_pkg::CMD_CTRL;
            default: begin
                n_cmd.kind = brp_pkg::CMD_CTRL;
                known      = 1'b0;
            end
        endcase
    end

    assign o_stall   = (r_cnt == (QW+1)'(brp_pkg::QDEPTH));
    assign push      = i_valid && !o_stall && known;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_cmd;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QW+1)'(push) - (QW+1)'(i_q_pop);
        end
    end

endmodule

// ===== rtl/brp_back.sv =====
`include "byte_ring_pipe_with_refcount_unit_defines.svh"
module brp_back #(
    parameter int PIPE_DEPTH = brp_pkg::PIPE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  brp_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_stall,
    output brp_pkg::t_out  o_rsp
);

    localparam int AW = $clog2(PIPE_DEPTH);
    localparam int CW = $clog2(PIPE_DEPTH + 1);
    localparam int SW = (CW > 12) ? CW + 1 : 13;

    logic [7:0]      mem [PIPE_DEPTH];
    logic [7:0]      r_rdata;
    logic [AW-1:0]   r_rpos, r_wpos;
    logic [CW-1:0]   r_cnt;
    logic            r_open;
    logic [15:0]     r_refs;
    logic            r_bact, r_bacc;
    logic [11:0]     r_bdone, r_blen;
    logic [1:0]      r_bcode;
    logic [6:0]      r_rleft;
    logic [11:0]     r_rdone;
    brp_pkg::t_bstate r_st, n_st;
    logic            r_ovalid;
    brp_pkg::t_out   r_orsp;

    logic            out_free;
    logic            take;
    logic            wr_en;
    logic            fits;
    logic [11:0]     nread;

    assign out_free = !r_ovalid || !i_stall;
    assign o_valid  = r_ovalid;
    assign o_rsp    = r_orsp;

    // Only take a new command while idle and the output slot can accept.
    assign take    = (r_st == brp_pkg::BS_IDLE) && i_q_valid && out_free;
    assign o_q_pop = take;

    assign nread = (SW'(r_cnt) < SW'(i_cmd.length)) ? 12'(r_cnt) : i_cmd.length;

    // Burst admission: open and room for the whole announced length.
    assign fits = r_open && (SW'(r_cnt) + SW'(i_cmd.length) <= SW'(PIPE_DEPTH));

    always_comb begin
        n_st = r_st;
        case (r_st)
            brp_pkg::BS_IDLE:
                if (take && i_cmd.kind == brp_pkg::CMD_READ && r_cnt != '0
                    && i_cmd.length != '0) n_st = brp_pkg::BS_RDLAT;
            brp_pkg::BS_RDLAT: n_st = brp_pkg::BS_RDOUT;
            brp_pkg::BS_RDOUT:
                if (out_free) n_st = (r_rleft == 7'd1) ? brp_pkg::BS_IDLE
                                                       : brp_pkg::BS_RDLAT;
            default: n_st = brp_pkg::BS_IDLE;
        endcase
    end

    // Write-gating for the current burst byte.
    always_comb begin
        logic       acc;
        logic [11:0] done;
        acc  = r_bacc;
        done = r_bdone;
        if (!r_bact) begin
            acc  = fits;
            done = '0;
        end
        wr_en = take && i_cmd.kind == brp_pkg::CMD_WRITE
                && !(!r_bact && i_cmd.length == '0)
                && acc && done < (r_bact ? r_blen : i_cmd.length)
                && r_cnt < CW'(PIPE_DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_wpos] <= i_cmd.data_byte;
        r_rdata <= mem[r_rpos];
    end

    always_ff @(posedge i_clk) begin
        logic          ov;
        brp_pkg::t_out orsp;
        ov   = r_ovalid;
        orsp = r_orsp;
        if (!i_rst_n) begin
            r_st     <= brp_pkg::BS_IDLE;
            r_rpos   <= '0;
            r_wpos   <= '0;
            r_cnt    <= '0;
            r_open   <= 1'b0;
            r_refs   <= '0;
            r_bact   <= 1'b0;
            r_bacc   <= 1'b0;
            r_bdone  <= '0;
            r_blen   <= '0;
            r_bcode  <= brp_pkg::ST_OK;
            r_rleft  <= '0;
            r_rdone  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (out_free) ov = 1'b0;
            if (take) begin
                orsp      = '0;
                orsp.last = 1'b1;
                case (i_cmd.kind)
                    brp_pkg::CMD_CTRL: begin
                        logic [15:0] refs_n;
                        logic        open_n;
                        logic [1:0]  stat;
                        refs_n = r_refs;
                        open_n = r_open;
                        stat   = brp_pkg::ST_OK;
                        case (i_cmd.func)
                            brp_pkg::FN_OPEN: begin
                                open_n = 1'b1;
                                refs_n = r_refs + 16'd1;
                            end
                            brp_pkg::FN_DUP:
                                if (r_open) refs_n = r_refs + 16'd1;
                                else stat = brp_pkg::ST_NCONN;
                            brp_pkg::FN_CLOSE:
                                if (r_open) refs_n = r_refs - 16'd1;
                            default:
                                if (r_open && r_refs == '0) open_n = 1'b0;
                        endcase
                        r_refs <= refs_n;
                        r_open <= open_n;
                        orsp.status    = stat;
                        orsp.ref_count = refs_n;
                        orsp.is_open   = open_n;
                        ov = 1'b1;
                    end
                    brp_pkg::CMD_WRITE: begin
                        logic        act, acc;
                        logic [11:0] done, blen;
                        logic [1:0]  code;
                        act  = r_bact;
                        acc  = r_bacc;
                        done = r_bdone;
                        blen = r_blen;
                        code = r_bcode;
                        orsp.ref_count = r_refs;
                        orsp.is_open   = r_open;
                        if (!r_bact && i_cmd.length == '0) begin
                            ov = 1'b1;
                        end else begin
                            if (!r_bact) begin
                                act  = 1'b1;
                                done = '0;
                                blen = i_cmd.length;
                                acc  = fits;
                                code = !r_open ? brp_pkg::ST_NCONN
                                     : (acc ? brp_pkg::ST_OK : brp_pkg::ST_NOSPC);
                            end
                            if (wr_en) begin
                                done   = done + 12'd1;
                                r_wpos <= (r_wpos == AW'(PIPE_DEPTH - 1)) ? '0
                                          : r_wpos + 1'b1;
                                r_cnt  <= r_cnt + 1'b1;
                            end
                            if (i_cmd.burst_last) begin
                                act = 1'b0;
                                orsp.status     = code;
                                orsp.done_count = acc ? done : '0;
                                ov = 1'b1;
                            end
                            r_bact  <= act;
                            r_bacc  <= acc;
                            r_bdone <= done;
                            r_blen  <= blen;
                            r_bcode <= code;
                        end
                    end
                    default: begin
                        orsp.ref_count = r_refs;
                        orsp.is_open   = r_open;
                        if (r_cnt == '0) begin
                            orsp.status = (r_refs <= 16'd1) ? brp_pkg::ST_NCONN
                                                            : brp_pkg::ST_BLOCK;
                            ov = 1'b1;
                        end else if (i_cmd.length == '0) begin
                            ov = 1'b1;
                        end else begin
                            r_rleft <= 7'(nread);
                            r_rdone <= nread;
                        end
                    end
                endcase
            end
            if (r_st == brp_pkg::BS_RDOUT && out_free) begin
                ov                   = 1'b1;
                orsp.status          = brp_pkg::ST_OK;
                orsp.out_byte        = r_rdata;
                orsp.byte_valid      = 1'b1;
                orsp.ref_count       = r_refs;
                orsp.is_open         = r_open;
                orsp.last            = (r_rleft == 7'd1);
                orsp.done_count      = (r_rleft == 7'd1) ? r_rdone : '0;
                r_rleft <= r_rleft - 7'd1;
                r_rpos  <= (r_rpos == AW'(PIPE_DEPTH - 1)) ? '0 : r_rpos + 1'b1;
                r_cnt   <= r_cnt - 1'b1;
            end
            r_ovalid <= ov;
            r_orsp   <= orsp;
        end
    end

    `BRP_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(PIPE_DEPTH), "count overflow")
    `BRP_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_st != brp_pkg::BS_IDLE, !o_q_pop, "pop while reading")
    `BRP_ASSERT_NXT(a_rd_valid, i_clk, i_rst_n, r_st == brp_pkg::BS_RDOUT && out_free, r_ovalid && r_orsp.byte_valid, "read byte lost")

endmodule

// ===== rtl/byte_ring_pipe_with_refcount_unit.sv =====
// Channel  Direction  Handshake            Payload
// in       input      i_valid / o_stall    brp_pkg::t_in   i_req
// out      output     o_valid / i_stall    brp_pkg::t_out  o_rsp
//
// Control and write requests are taken from the command queue by the back end while
// it is idle; each result passes through the queue and the registered output slot.
// A read is taken while idle, then each byte steps through BS_RDLAT, waiting on the
// ring memory's registered read port, and BS_RDOUT, where the byte is presented.
// Reset is synchronous, active low; the ring contents are not cleared.
// A stalled output holds the back end; o_stall rises once both queue entries fill.
module byte_ring_pipe_with_refcount_unit #(
    parameter int PIPE_DEPTH = brp_pkg::PIPE_DEPTH_DEF,
    parameter int MAX_READ   = brp_pkg::MAX_READ_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  brp_pkg::t_in   i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output brp_pkg::t_out  o_rsp
);

    logic          q_valid;
    logic          q_pop;
    brp_pkg::t_cmd q_cmd;

    // Front: classify requests, drop unused codes, queue commands.
    brp_front #(.MAX_READ(MAX_READ)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd)
    );

    // Back: own the ring, counters and reference state; emit results.
    brp_back #(.PIPE_DEPTH(PIPE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_cmd(q_cmd),
        .o_valid, .i_stall, .o_rsp
    );

endmodule
